/* hw/rtl/dpb_pkg.sv */
`timescale 1ns / 1ps

package dpb_pkg;

  // Image geometry
  localparam int DIM_BITS   = 12;
  localparam int DEPTH_BITS = 16;
  localparam int COLOR_BITS = 8;
  localparam int COORD_BITS = 32;

  // Largest frame dimension; width/height of 0 or above this act as this
  localparam logic [DIM_BITS:0] MAX_DIM = 13'd4096;

  // Configuration port
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int FINV_BITS      = 16;

  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_X      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_CENTER_Y      = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_FOCAL_INVERSE = 3'd4;

  // Register reset values
  localparam logic [DIM_BITS:0]    RST_IMAGE_WIDTH   = 13'd640;
  localparam logic [DIM_BITS:0]    RST_IMAGE_HEIGHT  = 13'd480;
  localparam logic [DIM_BITS-1:0]  RST_CENTER_X      = 12'd320;
  localparam logic [DIM_BITS-1:0]  RST_CENTER_Y      = 12'd240;
  localparam logic [FINV_BITS-1:0] RST_FOCAL_INVERSE = 16'd31957;

  // Datapath widths: (pos - center) * depth, then * focal_inverse (Q0.24)
  // The second product is held wide enough for a full 32-bit slice above the shift
  localparam int DIFF_BITS  = DIM_BITS + 1;
  localparam int PROD1_BITS = DIFF_BITS + DEPTH_BITS + 1;
  localparam int PROD2_BITS = PROD1_BITS + FINV_BITS + 2;
  localparam int ROUND_SHIFT = 16;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_DONE
  } dpb_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic mul1;
    logic mul2;
    logic load_out;
  } dpb_cmd_t;

endpackage

/* hw/rtl/dpb_ctrl.sv */
`timescale 1ns / 1ps

module dpb_ctrl
  import dpb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output dpb_cmd_t cmd
);

  dpb_state_t state;
  dpb_state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_MUL1;
      end
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_DONE;
      ST_DONE: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_MUL1: cmd.mul1 = 1'b1;
      ST_MUL2: cmd.mul2 = 1'b1;
      ST_DONE: cmd.load_out = !out_valid || !out_stall;
      default: cmd = '0;
    endcase
  end

  // Output register occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_MUL1))
    else $error("accepted item did not start the multiply sequence");

  a_mul_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL1) |=> (state == ST_MUL2))
    else $error("second multiply stage skipped");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result loaded over a stalled item");

  a_done_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && out_valid && out_stall) |=> (state == ST_DONE))
    else $error("finished result dropped while output stalled");

endmodule

/* hw/rtl/dpb_datapath.sv */
`timescale 1ns / 1ps

module dpb_datapath
  import dpb_pkg::*;
(
  input  logic                             clk,
  input  logic                             rst,
  input  dpb_cmd_t                         cmd,
  input  logic                             cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic [CFG_DATA_BITS-1:0]         cfg_data,
  input  logic [DEPTH_BITS-1:0]            depth,
  input  logic [COLOR_BITS-1:0]            red,
  input  logic [COLOR_BITS-1:0]            green,
  input  logic [COLOR_BITS-1:0]            blue,
  output logic signed [COORD_BITS-1:0]     point_x,
  output logic signed [COORD_BITS-1:0]     point_y,
  output logic [DEPTH_BITS-1:0]            point_z,
  output logic [COLOR_BITS-1:0]            out_red,
  output logic [COLOR_BITS-1:0]            out_green,
  output logic [COLOR_BITS-1:0]            out_blue,
  output logic                             point_valid,
  output logic                             frame_end
);

  // Configuration registers
  logic [DIM_BITS:0]    image_width;
  logic [DIM_BITS:0]    image_height;
  logic [DIM_BITS-1:0]  center_x;
  logic [DIM_BITS-1:0]  center_y;
  logic [FINV_BITS-1:0] focal_inverse;

  // Raster position
  logic [DIM_BITS-1:0]  column_count;
  logic [DIM_BITS-1:0]  row_count;
  logic [DIM_BITS:0]    width_eff;
  logic [DIM_BITS:0]    height_eff;
  logic                 last_col;
  logic                 last_row;

  // Captured item
  logic [DEPTH_BITS-1:0] cap_depth;
  logic [COLOR_BITS-1:0] cap_red;
  logic [COLOR_BITS-1:0] cap_green;
  logic [COLOR_BITS-1:0] cap_blue;
  logic [DIM_BITS-1:0]   cap_col;
  logic [DIM_BITS-1:0]   cap_row;
  logic                  cap_end;

  // Arithmetic
  logic signed [DIFF_BITS-1:0]    diff_x;
  logic signed [DIFF_BITS-1:0]    diff_y;
  logic signed [DEPTH_BITS:0]     depth_s;
  logic signed [FINV_BITS:0]      finv_s;
  logic signed [PROD1_BITS-1:0]   prod1_x;
  logic signed [PROD1_BITS-1:0]   prod1_y;
  logic signed [PROD2_BITS-1:0]   prod2_x;
  logic signed [PROD2_BITS-1:0]   prod2_y;
  logic signed [PROD2_BITS-1:0]   round_x;
  logic signed [PROD2_BITS-1:0]   round_y;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= RST_IMAGE_WIDTH;
      image_height  <= RST_IMAGE_HEIGHT;
      center_x      <= RST_CENTER_X;
      center_y      <= RST_CENTER_Y;
      focal_inverse <= RST_FOCAL_INVERSE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:   image_width   <= cfg_data[DIM_BITS:0];
        REG_IMAGE_HEIGHT:  image_height  <= cfg_data[DIM_BITS:0];
        REG_CENTER_X:      center_x      <= cfg_data[DIM_BITS-1:0];
        REG_CENTER_Y:      center_y      <= cfg_data[DIM_BITS-1:0];
        REG_FOCAL_INVERSE: focal_inverse <= cfg_data[FINV_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame size and wrap detection
  always_comb begin
    width_eff  = (image_width == '0 || image_width > MAX_DIM) ? MAX_DIM : image_width;
    height_eff = (image_height == '0 || image_height > MAX_DIM) ? MAX_DIM : image_height;
    last_col   = ({1'b0, column_count} + 1'b1) >= width_eff;
    last_row   = ({1'b0, row_count} + 1'b1) >= height_eff;
  end

  // Raster counters advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.capture) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_count + 1'b1;
      end else begin
        column_count <= column_count + 1'b1;
      end
    end
  end

  // Item capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_depth <= depth;
      cap_red   <= red;
      cap_green <= green;
      cap_blue  <= blue;
      cap_col   <= column_count;
      cap_row   <= row_count;
      cap_end   <= last_col && last_row;
    end
  end

  // First multiply: offset from principal point times depth
  assign diff_x  = $signed({1'b0, cap_col}) - $signed({1'b0, center_x});
  assign diff_y  = $signed({1'b0, cap_row}) - $signed({1'b0, center_y});
  assign depth_s = $signed({1'b0, cap_depth});

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod1_x <= diff_x * depth_s;
      prod1_y <= diff_y * depth_s;
    end
  end

  // Second multiply: scale by reciprocal focal length (Q0.24)
  assign finv_s = $signed({1'b0, focal_inverse});

  always_ff @(posedge clk) begin
    if (cmd.mul2) begin
      prod2_x <= prod1_x * finv_s;
      prod2_y <= prod1_y * finv_s;
    end
  end

  // Round half up to 8 fraction bits
  assign round_x = prod2_x + PROD2_BITS'(signed'(1 << (ROUND_SHIFT - 1)));
  assign round_y = prod2_y + PROD2_BITS'(signed'(1 << (ROUND_SHIFT - 1)));

  // Output register; empty point when depth is zero
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      frame_end <= cap_end;
      if (cap_depth == '0) begin
        point_x     <= '0;
        point_y     <= '0;
        point_z     <= '0;
        out_red     <= '0;
        out_green   <= '0;
        out_blue    <= '0;
        point_valid <= 1'b0;
      end else begin
        point_x     <= round_x[ROUND_SHIFT +: COORD_BITS];
        point_y     <= round_y[ROUND_SHIFT +: COORD_BITS];
        point_z     <= cap_depth;
        out_red     <= cap_red;
        out_green   <= cap_green;
        out_blue    <= cap_blue;
        point_valid <= 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/depth_pixel_backprojection.sv */
`timescale 1ns / 1ps
// An accepted item passes through capture, two registered multiply stages
//   (offset*depth, then *focal_inverse) and output load; the sequencer takes
//   no new item until that item has been loaded into the output register.
// A stalled output holds the sequencer in its last step; one item waits in the output register.
// Reset (rst, synchronous, active high): sequencer idle, output empty, raster counters zero,
//   configuration registers back to 640 x 480, center (320, 240), focal_inverse 31957.

module depth_pixel_backprojection
  import dpb_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [CFG_DATA_BITS-1:0]      cfg_data,
  // pixel input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [DEPTH_BITS-1:0]         depth,
  input  logic [COLOR_BITS-1:0]         red,
  input  logic [COLOR_BITS-1:0]         green,
  input  logic [COLOR_BITS-1:0]         blue,
  // point output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  point_x,
  output logic signed [COORD_BITS-1:0]  point_y,
  output logic [DEPTH_BITS-1:0]         point_z,
  output logic [COLOR_BITS-1:0]         out_red,
  output logic [COLOR_BITS-1:0]         out_green,
  output logic [COLOR_BITS-1:0]         out_blue,
  output logic                          point_valid,
  output logic                          frame_end
);

  dpb_cmd_t cmd;

  // Sequencer
  dpb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Counters, multipliers and output register
  dpb_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .depth       (depth),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .point_x     (point_x),
    .point_y     (point_y),
    .point_z     (point_z),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .point_valid (point_valid),
    .frame_end   (frame_end)
  );

endmodule

/* test/tb_depth_pixel_backprojection.sv */
`timescale 1ns / 1ps

module tb_depth_pixel_backprojection;
  import dpb_pkg::*;

  typedef struct packed {
    logic [DEPTH_BITS-1:0] depth;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [DEPTH_BITS-1:0] z;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic                  is_valid;
    logic                  frame_end;
  } point_t;

  // DUT signals, all inputs known from time zero
  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]     cfg_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [DEPTH_BITS-1:0]        depth = '0;
  logic [COLOR_BITS-1:0]        red = '0;
  logic [COLOR_BITS-1:0]        green = '0;
  logic [COLOR_BITS-1:0]        blue = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic [DEPTH_BITS-1:0]        point_z;
  logic [COLOR_BITS-1:0]        out_red;
  logic [COLOR_BITS-1:0]        out_green;
  logic [COLOR_BITS-1:0]        out_blue;
  logic                         point_valid;
  logic                         frame_end;

  depth_pixel_backprojection uut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the camera registers and the raster position
  int              img_w = RST_IMAGE_WIDTH;
  int              img_h = RST_IMAGE_HEIGHT;
  int              ctr_x = RST_CENTER_X;
  int              ctr_y = RST_CENTER_Y;
  logic [15:0]     focal_inv = RST_FOCAL_INVERSE;
  int              col_count = 0;
  int              row_count = 0;

  pixel_t pixel_queue[$];
  point_t expected_points[$];
  pixel_t pixel_on_port;

  int pixels_queued = 0;
  int pixels_accepted = 0;
  int points_seen = 0;
  int frame_ends = 0;
  int empty_points = 0;
  int settings_used = 0;
  int mismatches = 0;
  int in_gap_left = 0;
  int in_gap_pct = 0;
  int stall_left = 0;
  int stall_pct = 0;

  // 0 or anything past the largest frame acts as the largest frame
  function automatic int effective_dim(int v);
    return (v == 0 || v > MAX_DIM) ? int'(MAX_DIM) : v;
  endfunction

  // (pos - center) * depth * finv is Q.24; round half up to 8 fraction bits
  function automatic logic [31:0] back_project(int pos, int center, logic [15:0] d,
                                               logic [15:0] finv);
    longint prod;
    longint rounded;
    prod = longint'(pos - center) * longint'(d) * longint'(finv);
    rounded = (prod + 64'sd32768) >>> 16;
    return rounded[31:0];
  endfunction

  // Expected point for one pixel; advances the raster position
  function automatic point_t project_pixel(pixel_t p);
    point_t pt;
    bit     last_col;
    bit     last_row;
    last_col = (col_count + 1) >= effective_dim(img_w);
    last_row = (row_count + 1) >= effective_dim(img_h);
    pt = '0;
    if (p.depth != 0) begin
      pt.x = back_project(col_count, ctr_x, p.depth, focal_inv);
      pt.y = back_project(row_count, ctr_y, p.depth, focal_inv);
      pt.z = p.depth;
      pt.red = p.red;
      pt.green = p.green;
      pt.blue = p.blue;
      pt.is_valid = 1'b1;
    end
    pt.frame_end = last_col && last_row;
    if (last_col) begin
      col_count = 0;
      row_count = last_row ? 0 : row_count + 1;
    end else begin
      col_count = col_count + 1;
    end
    return pt;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: point %0d %s expected %h actual %h", $time, points_seen, name, want, got);
    end
  endtask

  // Pixel driver: holds a stalled item, else inserts idle bursts or sends the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_points = {expected_points, project_pixel(pixel_on_port)};
        pixels_accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (in_gap_left > 0) begin
          in_valid <= 1'b0;
          in_gap_left--;
        end else if (pixel_queue.size() > 0 && $urandom_range(99) < in_gap_pct) begin
          in_valid <= 1'b0;
          in_gap_left = $urandom_range(15, 1) - 1;
        end else if (pixel_queue.size() > 0) begin
          pixel_on_port = pixel_queue.pop_front();
          in_valid <= 1'b1;
          depth <= pixel_on_port.depth;
          red <= pixel_on_port.red;
          green <= pixel_on_port.green;
          blue <= pixel_on_port.blue;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Point monitor: compare against the oldest expectation, stall in bursts
  always @(posedge clk) begin : point_monitor
    point_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        points_seen++;
        if (expected_points.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected point, expected none actual x=%h y=%h z=%h",
                   $time, point_x, point_y, point_z);
        end else begin
          want = expected_points.pop_front();
          check_field("point_x", want.x, point_x);
          check_field("point_y", want.y, point_y);
          check_field("point_z", 32'(want.z), 32'(point_z));
          check_field("out_red", 32'(want.red), 32'(out_red));
          check_field("out_green", 32'(want.green), 32'(out_green));
          check_field("out_blue", 32'(want.blue), 32'(out_blue));
          check_field("point_valid", 32'(want.is_valid), 32'(point_valid));
          check_field("frame_end", 32'(want.frame_end), 32'(frame_end));
          if (want.frame_end) frame_ends++;
          if (!want.is_valid) empty_points++;
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if ($urandom_range(99) < stall_pct) begin
        out_stall <= 1'b1;
        stall_left = $urandom_range(15, 1) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_pixel(logic [15:0] d, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    pixel_t p;
    p.depth = d;
    p.red = r;
    p.green = g;
    p.blue = b;
    pixel_queue = {pixel_queue, p};
    pixels_queued++;
  endtask

  function automatic logic [15:0] pick_depth();
    case ($urandom_range(15))
      0, 1:    return 16'd0;
      2:       return 16'hFFFF;
      3:       return 16'd1;
      4:       return 16'($urandom_range(255, 1));
      default: return 16'($urandom);
    endcase
  endfunction

  // Mostly tiny frames so frame ends and wraps come often
  function automatic int pick_dim();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return $urandom_range(8, 1);
      5:             return 1;
      6:             return $urandom_range(1) ? 0 : int'(MAX_DIM);
      7:             return $urandom_range(8191, 4097);
      8:             return $urandom_range(64, 9);
      default:       return $urandom_range(8191);
    endcase
  endfunction

  function automatic int pick_center();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 4095;
      2:       return $urandom_range(16);
      default: return $urandom_range(4095);
    endcase
  endfunction

  function automatic int pick_focal();
    case ($urandom_range(5))
      0:       return 0;
      1:       return 65535;
      2:       return RST_FOCAL_INVERSE;
      default: return $urandom_range(65535);
    endcase
  endfunction

  // Waits until every queued pixel has been accepted and has come back as a point
  task automatic drain();
    while (pixels_accepted != pixels_queued || expected_points.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  task automatic configure(int w, int h, int cx, int cy, int fi);
    img_w = w & 'h1FFF;
    img_h = h & 'h1FFF;
    ctr_x = cx & 'hFFF;
    ctr_y = cy & 'hFFF;
    focal_inv = 16'(fi);
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_BITS'(img_w));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_BITS'(img_h));
    write_reg(REG_CENTER_X, CFG_DATA_BITS'(ctr_x));
    write_reg(REG_CENTER_Y, CFG_DATA_BITS'(ctr_y));
    write_reg(REG_FOCAL_INVERSE, focal_inv);
    @(posedge clk);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int phase;
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    in_gap_pct = 20;
    stall_pct = 20;

    // Reset geometry: empty pixels drop colour, depth extremes
    push_pixel(16'h0000, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(16'h0001, 8'h00, 8'h00, 8'h00);
    push_pixel(16'h8000, 8'hAA, 8'h55, 8'h0F);
    push_pixel(16'h7FFF, 8'h55, 8'hAA, 8'hF0);
    push_pixel(16'h0000, 8'h00, 8'h00, 8'h00);
    drain();

    // Shrink to 3x2 mid-row: column already past the new width wraps
    configure(3, 2, 0, 4095, 65535);
    push_pixel(16'hFFFF, 8'h12, 8'h34, 8'h56);
    push_pixel(16'hFFFF, 8'hFF, 8'h00, 8'hFF);
    push_pixel(16'h0000, 8'h80, 8'h80, 8'h80);
    push_pixel(16'hFFFF, 8'h00, 8'hFF, 8'h00);
    push_pixel(16'h0001, 8'h01, 8'h02, 8'h03);
    push_pixel(16'hFFFF, 8'hFE, 8'hFD, 8'hFC);
    push_pixel(16'h0000, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(16'hFFFF, 8'h7F, 8'h7F, 8'h7F);
    drain();

    // Zero width and oversize height act as the largest frame; zero focal inverse
    configure(0, 8191, 4095, 0, 0);
    push_pixel(16'hFFFF, 8'h11, 8'h22, 8'h33);
    push_pixel(16'h1234, 8'h44, 8'h55, 8'h66);
    push_pixel(16'h0000, 8'h77, 8'h88, 8'h99);
    drain();

    // 1x1 frame: every pixel ends a frame, most negative offsets
    configure(1, 1, 4095, 4095, 65535);
    push_pixel(16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    push_pixel(16'h0000, 8'h00, 8'h00, 8'h00);
    push_pixel(16'h8001, 8'hC3, 8'h3C, 8'h5A);
    drain();

    // Width just past the largest frame, unit focal inverse
    configure(4097, 2, 0, 0, 1);
    push_pixel(16'hFFFF, 8'h01, 8'h80, 8'hFE);
    push_pixel(16'h00FF, 8'h10, 8'h20, 8'h30);
    push_pixel(16'hFFFF, 8'hAB, 8'hCD, 8'hEF);
    drain();

    // Random geometry and pixels; the last phases run without idling
    for (phase = 0; phase < 11; phase++) begin
      if (phase >= 9) begin
        in_gap_pct = 0;
        stall_pct = 0;
      end else begin
        in_gap_pct = (phase % 3 == 0) ? 0 : $urandom_range(40, 5);
        stall_pct = (phase % 4 == 1) ? 0 : $urandom_range(40, 5);
      end
      configure(pick_dim(), pick_dim(), pick_center(), pick_center(), pick_focal());
      for (k = 0; k < 120; k++)
        push_pixel(pick_depth(), 8'($urandom), 8'($urandom), 8'($urandom));
      drain();
    end

    repeat (10) @(posedge clk);
    $display("Covered %0d pixels over %0d register settings plus reset geometry,",
             pixels_accepted, settings_used);
    $display("with %0d frame ends and %0d empty points, under random idle and stall.",
             frame_ends, empty_points);
    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
